[src/utf8_stream_sanitizer_core_macros.svh]
// Assertion macros for the UTF-8 stream sanitiser.
`ifndef UTF8_STREAM_SANITIZER_CORE_MACROS_SVH
`define UTF8_STREAM_SANITIZER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds at every clock edge out of reset.
`define U8S_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// Check that a condition in one cycle leads to another in the next.
`define U8S_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define U8S_ASSERT(label, prop, msg)
`define U8S_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[src/utf8san_pkg.sv]
// Types, constants and byte classification for the UTF-8 stream sanitiser.
package utf8san_pkg;

    localparam logic [7:0] SUB_CHAR   = 8'h3F;
    localparam int         FIFO_DEPTH = 8;
    localparam int         PTR_W      = $clog2(FIFO_DEPTH);
    localparam int         MAX_BURST  = 4;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CTRL,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } out_entry_t;

    // Classifies a byte seen with no sequence open.
    function automatic byte_kind_t classify_byte(input logic [7:0] b);
        byte_kind_t kind;
        if (!b[7]) begin
            if (b < 8'h20 && b != 8'h09 && b != 8'h0A && b != 8'h0D)
                kind = KIND_CTRL;
            else
                kind = KIND_ASCII;
        end else if (b[7:5] == 3'h6) begin
            kind = KIND_LEAD2;
        end else if (b[7:4] == 4'hE) begin
            kind = KIND_LEAD3;
        end else if (b[7:3] == 5'h1E) begin
            kind = KIND_LEAD4;
        end else begin
            kind = KIND_BAD;
        end
        return kind;
    endfunction

endpackage

[src/utf8_stream_sanitizer_core.sv]
// UTF-8 stream sanitiser: validates multi-byte sequences and replaces bad bytes.
//
//  channel | direction | tdata          | tuser       | tlast
//  s_      | in        | [7:0] in_byte  | -           | end_of_string
//  m_      | out       | [7:0] out_byte | [0] run_end | string_end
//
// One input item is taken per cycle; it is examined from the input register,
// and its zero to four results go into an eight-entry queue.
// Results leave the queue at one per cycle while m_tready is high.
// The input register holds its item while the queue has fewer than four free
// entries, which back-pressures s_tready.
// Reset (aresetn low at a clock edge) empties the queue and closes any open sequence.
module utf8_stream_sanitizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] run_end
    output logic       m_tlast
);
    import utf8san_pkg::*;

    `include "utf8_stream_sanitizer_core_macros.svh"

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // Sequence state
    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [2:0] seq_len_reg, seq_len_next;
    logic       hold_wr;
    logic [1:0] hold_idx;

    // Result queue
    out_entry_t       fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fifo_cnt_reg;

    logic       consume;
    logic       in_accept;
    logic       pop;
    logic [7:0] emit_byte [MAX_BURST];
    logic [2:0] emit_cnt;
    logic [2:0] push_cnt;

    assign consume   = in_valid_reg && (fifo_cnt_reg <= (PTR_W+1)'(FIFO_DEPTH - MAX_BURST));
    assign s_tready  = !in_valid_reg || consume;
    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign push_cnt  = consume ? emit_cnt : 3'd0;

    always_comb begin
        byte_kind_t kind;
        logic       seq_open;
        logic       is_cont;
        kind          = classify_byte(in_byte_reg);
        seq_open      = (seq_len_reg != 3'd0) && (held_cnt_reg != 2'd0);
        is_cont       = (in_byte_reg[7:6] == 2'b10);
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        hold_wr       = 1'b0;
        hold_idx      = 2'd0;
        emit_cnt      = 3'd0;
        for (int i = 0; i < MAX_BURST; i++)
            emit_byte[i] = SUB_CHAR;

        if (seq_open && is_cont) begin
            if (({1'b0, held_cnt_reg} + 3'd1) >= seq_len_reg) begin
                // Sequence complete: release the held bytes and this one.
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) < held_cnt_reg) begin
                        emit_byte[emit_cnt[1:0]] = held_bytes_reg[j];
                        emit_cnt = emit_cnt + 3'd1;
                    end
                end
                emit_byte[emit_cnt[1:0]] = in_byte_reg;
                emit_cnt      = emit_cnt + 3'd1;
                held_cnt_next = 2'd0;
                seq_len_next  = 3'd0;
            end else begin
                hold_wr       = 1'b1;
                hold_idx      = held_cnt_reg;
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end else begin
            if (seq_open) begin
                // Broken sequence: every held byte becomes a substitute.
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) < held_cnt_reg)
                        emit_cnt = emit_cnt + 3'd1;
                end
            end
            held_cnt_next = 2'd0;
            seq_len_next  = 3'd0;
            case (kind)
                KIND_ASCII: begin
                    emit_byte[emit_cnt[1:0]] = in_byte_reg;
                    emit_cnt = emit_cnt + 3'd1;
                end
                KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
                    hold_wr       = 1'b1;
                    hold_idx      = 2'd0;
                    held_cnt_next = 2'd1;
                    seq_len_next  = (kind == KIND_LEAD2) ? 3'd2 :
                                    (kind == KIND_LEAD3) ? 3'd3 : 3'd4;
                end
                default: begin
                    emit_cnt = emit_cnt + 3'd1;
                end
            endcase
        end

        // A string that ends inside a sequence flushes what is held.
        if (in_eos_reg && seq_len_next != 3'd0) begin
            emit_cnt      = emit_cnt + 3'd1;
            if (held_cnt_next >= 2'd2)
                emit_cnt = emit_cnt + 3'd1;
            if (held_cnt_next == 2'd3)
                emit_cnt = emit_cnt + 3'd1;
            held_cnt_next = 2'd0;
            seq_len_next  = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            held_cnt_reg <= 2'd0;
            seq_len_reg  <= 3'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;
            if (consume) begin
                held_cnt_reg <= held_cnt_next;
                seq_len_reg  <= seq_len_next;
            end
            wr_ptr_reg   <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fifo_cnt_reg <= fifo_cnt_reg + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (consume && hold_wr)
            held_bytes_reg[hold_idx] <= in_byte_reg;
        for (int i = 0; i < MAX_BURST; i++) begin
            if (3'(i) < push_cnt) begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= '{
                    out_byte:   emit_byte[i],
                    run_end:    (3'(i) == push_cnt - 3'd1),
                    string_end: (3'(i) == push_cnt - 3'd1) && in_eos_reg
                };
            end
        end
    end

    assign m_tvalid   = (fifo_cnt_reg != '0);
    assign m_tdata    = fifo_reg[rd_ptr_reg].out_byte;
    assign m_tuser[0] = fifo_reg[rd_ptr_reg].run_end;
    assign m_tlast    = fifo_reg[rd_ptr_reg].string_end;

    `U8S_ASSERT(a_fifo_bound, fifo_cnt_reg <= (PTR_W+1)'(FIFO_DEPTH), "result queue overflow")
    `U8S_ASSERT(a_state_agree, (held_cnt_reg == 2'd0) == (seq_len_reg == 3'd0), "held count and sequence length disagree")
    `U8S_ASSERT(a_last_is_run_end, !(m_tvalid && m_tlast) || m_tuser[0], "string end without run end")
    `U8S_ASSERT_NEXT(a_eos_closes, consume && in_eos_reg, seq_len_reg == 3'd0, "sequence left open after string end")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the UTF-8 stream sanitiser core.
`timescale 1ns / 100ps

module testbench;
    import utf8san_pkg::*;

    localparam int RANDOM_ITEMS = 195;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic [0:0] m_tuser;   // [0] run_end
    logic       m_tlast;

    // Mirror of the sequence tracker inside the block.
    logic [7:0] held_seq [0:2];
    int         held_n;
    int         seq_len;

    out_entry_t awaited_results [$];
    logic [7:0] produced [$];
    logic [7:0] text [$];

    int mismatch_count;
    int cycle_count;
    int burst_left;
    int random_sent;
    int tready_mode;
    int tready_hold;

    utf8_stream_sanitizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // A byte seen with no sequence open: pass, replace, or open a sequence.
    function automatic void take_fresh(input logic [7:0] b);
        if (!b[7]) begin
            if (b < SPACE_BYTE && b != TAB_BYTE && b != LF_BYTE && b != CR_BYTE)
                produced.push_back(SUB_CHAR);
            else
                produced.push_back(b);
        end else begin
            if (b[7:5] == 3'b110)
                seq_len = 2;
            else if (b[7:4] == 4'b1110)
                seq_len = 3;
            else if (b[7:3] == 5'b11110)
                seq_len = 4;
            if (seq_len == 0) begin
                produced.push_back(SUB_CHAR);
            end else begin
                held_seq[0] = b;
                held_n = 1;
            end
        end
    endfunction

    function automatic void flush_held();
        repeat (held_n) produced.push_back(SUB_CHAR);
        held_n = 0;
        seq_len = 0;
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void sanitise_byte(input logic [7:0] b, input logic eos);
        out_entry_t e;
        produced.delete();
        if (seq_len == 0) begin
            take_fresh(b);
        end else if (b[7:6] == 2'b10) begin
            if (held_n + 1 >= seq_len) begin
                for (int j = 0; j < held_n; j++)
                    produced.push_back(held_seq[j]);
                produced.push_back(b);
                held_n = 0;
                seq_len = 0;
            end else begin
                held_seq[held_n] = b;
                held_n++;
            end
        end else begin
            flush_held();
            take_fresh(b);
        end
        if (eos && seq_len != 0)
            flush_held();
        foreach (produced[k]) begin
            e.out_byte   = produced[k];
            e.run_end    = (k == produced.size() - 1);
            e.string_end = (k == produced.size() - 1) && eos;
            awaited_results.push_back(e);
        end
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Prediction on input handshakes, comparison on output handshakes.
    always @(posedge aclk) begin
        out_entry_t want;
        if (!aresetn) begin
            held_n = 0;
            seq_len = 0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    log_mismatch($sformatf("unexpected item byte=%h run_end=%b string_end=%b",
                                           m_tdata, m_tuser[0], m_tlast));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.out_byte || m_tuser[0] !== want.run_end ||
                        m_tlast !== want.string_end)
                        log_mismatch($sformatf({"expected byte=%h run_end=%b string_end=%b,",
                                                " got byte=%h run_end=%b string_end=%b"},
                                               want.out_byte, want.run_end, want.string_end,
                                               m_tdata, m_tuser[0], m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                sanitise_byte(s_tdata, s_tlast);
        end
    end

    // The receiver switches between steady, random, sparse and periodic readiness.
    always @(posedge aclk) begin
        if (tready_hold == 0) begin
            tready_mode = $urandom_range(0, 3);
            tready_hold = $urandom_range(8, 64);
        end else begin
            tready_hold--;
        end
        case (tready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= (cycle_count % 5 != 2);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL utf8_stream_sanitizer_core");
            $finish;
        end
    end

    // Sends one item; the sender idles for a random gap at the end of each burst.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic test_ascii_controls();
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_complete_sequences();
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Stray continuation, a byte above 0xF7, broken sequences and a string cut short.
    task automatic test_bad_and_broken();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    // Appends one character: mostly well formed, otherwise noise or a truncated sequence.
    function automatic void add_char();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: text.push_back(8'($urandom_range(8'h00, 8'h7F)));
            6:       text.push_back(8'($urandom_range(8'h00, 8'hFF)));
            8:       text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            9:       text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            default: begin
                if (pick == 7) begin
                    n = $urandom_range(2, 4);
                    k = $urandom_range(0, n - 2);
                end else begin
                    n = pick - 1;
                    k = n - 1;
                end
                case (n)
                    2:       text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    3:       text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                endcase
                repeat (k) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endfunction

    task automatic test_random_strings();
        while (random_sent < RANDOM_ITEMS) begin
            text.delete();
            repeat ($urandom_range(1, 6)) add_char();
            foreach (text[i])
                send_byte(text[i], i == text.size() - 1);
            random_sent += text.size();
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'h00;
        s_tlast        <= 1'b0;
        m_tready       <= 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        random_sent    = 0;
        tready_mode    = 0;
        tready_hold    = 0;
        held_n         = 0;
        seq_len        = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ascii_controls();
        test_complete_sequences();
        test_bad_and_broken();
        test_random_strings();
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("PASS utf8_stream_sanitizer_core");
        else
            $display("FAIL utf8_stream_sanitizer_core");
        $finish;
    end

endmodule
